// ----- rtl/ktpl_pkg.sv -----
// Package: shared types, codes and defaults for the k-nomial tree peer lookup.
`default_nettype none

package ktpl_pkg;

    // Defaults for the top-level parameters
    localparam int GROUP_MAX_DEF = 256;
    localparam int RANK_BITS_DEF = 16;

    // Command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int GCOUNT_W = 9;
    localparam int OWN_W    = 8;
    localparam int RADIX_W  = 9;
    localparam int EIDX_W   = 8;
    localparam int RANKF_W  = 16;
    localparam int LVL_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    // Walk arithmetic: offsets and candidates stay below own + 2 * group size
    localparam int WALK_W = 10;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Tree modes
    localparam logic MODE_BINOMIAL = 1'b0;
    localparam logic MODE_KNOMIAL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_RADIX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_MODE   = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [EIDX_W-1:0]  entry_index;
        logic [RANKF_W-1:0] entry_rank;
        logic [RANKF_W-1:0] source_rank;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [EIDX_W-1:0] peer_index;
        logic [LVL_W-1:0]  level;
    } out_word_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic               is_lookup;
        logic [EIDX_W-1:0]  index;
        logic [RANKF_W-1:0] rank;
    } cmd_t;

    typedef struct packed {
        logic [GCOUNT_W-1:0] group_count;
        logic [OWN_W-1:0]    own_index;
        logic [RADIX_W-1:0]  tree_radix;
        logic                tree_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } walk_state_t;

endpackage

`default_nettype wire

// ----- rtl/ktpl_front.sv -----
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none

module ktpl_front
    import ktpl_pkg::*;
#(
    parameter int GROUP_MAX = GROUP_MAX_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_word,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              keep;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    // writes beyond the table are dropped here
    always_comb
    begin
        cmd_in.is_lookup = (in_word.opcode == OP_LOOKUP);
        cmd_in.index     = in_word.entry_index;
        cmd_in.rank      = (in_word.opcode == OP_LOOKUP) ? in_word.source_rank
                                                         : in_word.entry_rank;
        keep = (in_word.opcode == OP_LOOKUP) || (32'(in_word.entry_index) < GROUP_MAX);
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QUEUE_DEPTH)) |-> !push)
        else $error("push into full queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// ----- rtl/ktpl_walker.sv -----
// Back end: rank table, tree walk sequencer and result register.
`default_nettype none

module ktpl_walker
    import ktpl_pkg::*;
#(
    parameter int GROUP_MAX = GROUP_MAX_DEF,
    parameter int RANK_BITS = RANK_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_word_t  out_word
);

    localparam int ADDR_W = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;

    logic [RANK_BITS-1:0] mem [GROUP_MAX];
    logic [RANK_BITS-1:0] rd_data_reg;

    walk_state_t          state_reg, state_next;

    logic [WALK_W-1:0]    offset_reg, offset_next;
    logic [WALK_W-1:0]    rpow_reg,   rpow_next;
    logic [RADIX_W-1:0]   digit_reg,  digit_next;
    logic [LVL_W-1:0]     lvl_reg,    lvl_next;
    logic [WALK_W-1:0]    gs_reg,     gs_next;
    logic [RANK_BITS-1:0] srank_reg,  srank_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [WALK_W-1:0]    pend_idx_reg,   pend_idx_next;
    logic [LVL_W-1:0]     pend_lvl_reg,   pend_lvl_next;
    logic                 res_found_reg,  res_found_next;
    logic [EIDX_W-1:0]    res_idx_reg,    res_idx_next;
    logic [LVL_W-1:0]     res_lvl_reg,    res_lvl_next;
    logic                 out_valid_reg,  out_valid_next;
    out_word_t            out_word_reg,   out_word_next;

    logic [WALK_W-1:0]    gs_cfg;
    logic [RADIX_W-1:0]   radix_eff;
    logic [RANK_BITS-1:0] cmd_rank;
    logic [31:0]          cmd_rank_ext;
    logic                 match;
    logic                 walk_more;
    logic                 is_peer;
    logic [WALK_W-1:0]    cand;
    logic                 issue;
    logic [31:0]          cand_ext;
    logic [31:0]          widx_ext;
    logic                 mem_we;
    logic                 slot_free;
    logic                 pop_lookup;

    // effective group size and radix
    always_comb
    begin
        gs_cfg = (32'(cfg.group_count) > GROUP_MAX) ? WALK_W'(GROUP_MAX)
                                                   : WALK_W'(cfg.group_count);
        radix_eff = (cfg.tree_radix < RADIX_W'(2)) ? RADIX_W'(2) : cfg.tree_radix;
        cmd_rank_ext = 32'(cmd.rank);
        cmd_rank = cmd_rank_ext[RANK_BITS-1:0];
    end

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pop_lookup = cmd_valid && cmd_ready && cmd.is_lookup;
    assign mem_we     = cmd_valid && cmd_ready && !cmd.is_lookup;
    assign match      = pend_valid_reg && (rd_data_reg == srank_reg);
    assign walk_more  = (offset_reg < gs_reg);
    assign slot_free  = !out_valid_reg || out_ready;

    // candidate of this walk step
    always_comb
    begin
        cand       = '0;
        is_peer    = 1'b0;
        offset_next = offset_reg;
        rpow_next   = rpow_reg;
        digit_next  = digit_reg;
        lvl_next    = lvl_reg;
        if (cfg.tree_mode == MODE_BINOMIAL)
        begin
            cand        = {{(WALK_W-OWN_W){1'b0}}, cfg.own_index} ^ offset_reg;
            is_peer     = 1'b1;
            offset_next = {offset_reg[WALK_W-2:0], 1'b0};
            lvl_next    = lvl_reg + LVL_W'(1);
        end
        else if (digit_reg != '0)
        begin
            // offset is not a multiple of radix * rpow
            if (WALK_W'(cfg.own_index) >= offset_reg)
            begin
                cand = WALK_W'(cfg.own_index) - offset_reg;
            end
            else
            begin
                cand = WALK_W'(cfg.own_index) + gs_reg - offset_reg;
            end
            is_peer     = 1'b1;
            offset_next = offset_reg + rpow_reg;
            if ((WALK_W'(digit_reg) + WALK_W'(1)) == WALK_W'(radix_eff))
            begin
                digit_next = '0;
            end
            else
            begin
                digit_next = digit_reg + RADIX_W'(1);
            end
        end
        else
        begin
            // level step: offset equals radix * rpow here
            rpow_next  = offset_reg;
            digit_next = RADIX_W'(1);
            lvl_next   = lvl_reg + LVL_W'(1);
        end
        issue    = is_peer && (cand < gs_reg);
        cand_ext = 32'(cand);
        widx_ext = 32'(cmd.index);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_lookup)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (match || (!walk_more && !pend_valid_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        gs_next         = gs_reg;
        srank_next      = srank_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_lvl_next   = pend_lvl_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        res_lvl_next    = res_lvl_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_lookup)
                begin
                    gs_next    = gs_cfg;
                    srank_next = cmd_rank;
                end
            end
            ST_WALK:
            begin
                if (match)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = pend_idx_reg[EIDX_W-1:0];
                    res_lvl_next   = pend_lvl_reg;
                end
                else if (walk_more)
                begin
                    pend_valid_next = issue;
                    pend_idx_next   = cand;
                    pend_lvl_next   = lvl_reg;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    res_lvl_next   = '0;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.found      = res_found_reg;
                    out_word_next.peer_index = res_idx_reg;
                    out_word_next.level      = res_lvl_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // walk counters: loaded at dispatch, stepped while walking
    always_ff @(posedge clk)
    begin
        if (pop_lookup)
        begin
            offset_reg <= WALK_W'(1);
            rpow_reg   <= WALK_W'(1);
            digit_reg  <= RADIX_W'(1);
            lvl_reg    <= '0;
        end
        else if ((state_reg == ST_WALK) && walk_more)
        begin
            offset_reg <= offset_next;
            rpow_reg   <= rpow_next;
            digit_reg  <= digit_next;
            lvl_reg    <= lvl_next;
        end
        gs_reg        <= gs_next;
        srank_reg     <= srank_next;
        pend_idx_reg  <= pend_idx_next;
        pend_lvl_reg  <= pend_lvl_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_lvl_reg   <= res_lvl_next;
        out_word_reg  <= out_word_next;
    end

    // rank table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[widx_ext[ADDR_W-1:0]] <= cmd_rank;
        end
        if ((state_reg == ST_WALK) && issue)
        begin
            rd_data_reg <= mem[cand_ext[ADDR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_pend_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_idx_reg < gs_reg))
        else $error("table read outside the group");

    a_pend_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_WALK))
        else $error("pending compare outside walk");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.found) |->
            (out_word_reg.peer_index == '0 && out_word_reg.level == '0))
        else $error("not-found word carries index or level");

    a_no_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !mem_we)
        else $error("table write during walk");

endmodule

`default_nettype wire

// ----- rtl/knomial_tree_peer_lookup.sv -----
// Table writes: a write lands in the table at the edge it leaves the queue, the cycle after
// acceptance when the back end is idle. A lookup walks the candidate peers (up to the group
// size) and the tree levels between dispatch and result.
// Throughput: one lookup at a time; the single table read port checks at most one peer a cycle.
// Reset: configuration returns to group_count 1, own_index 0, tree_radix 2,
// tree_mode k-nomial; queue and output empty; the rank table is not cleared.
`default_nettype none

module knomial_tree_peer_lookup
    import ktpl_pkg::*;
#(
    parameter int GROUP_MAX = GROUP_MAX_DEF,
    parameter int RANK_BITS = RANK_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
    // input words
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_word_t             in_word,
    // result words
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_word_t                 out_word
);

    // Configuration registers. The user must write them only while the block is idle (the block
    // does not enforce this itself), so the back end reads them directly during a walk.
    cfg_t cfg_reg, cfg_next;

    // Front-to-back command queue handshake
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GROUP_COUNT: cfg_next.group_count = cfg_wdata[GCOUNT_W-1:0];
                CFG_OWN_INDEX:   cfg_next.own_index   = cfg_wdata[OWN_W-1:0];
                CFG_TREE_RADIX:  cfg_next.tree_radix  = cfg_wdata[RADIX_W-1:0];
                CFG_TREE_MODE:   cfg_next.tree_mode   = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_count <= GCOUNT_W'(1);
            cfg_reg.own_index   <= '0;
            cfg_reg.tree_radix  <= RADIX_W'(2);
            cfg_reg.tree_mode   <= MODE_KNOMIAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes each word, drops out-of-range writes, queues the rest.
    ktpl_front #(
        .GROUP_MAX (GROUP_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: applies table writes and walks the tree peers for lookups;
    // its output register lets the front keep filling the queue.
    ktpl_walker #(
        .GROUP_MAX (GROUP_MAX),
        .RANK_BITS (RANK_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- sim/tb_knomial_tree_peer_lookup.sv -----
// Testbench for the k-nomial tree peer lookup: table loads and lookups checked against a predictor.
`default_nettype none

module tb_knomial_tree_peer_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import ktpl_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value
    // from time zero; inputs move on the falling edge only.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_word_t             in_word   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_word_t            out_word;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    knomial_tree_peer_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // ------------------------------------------------------------------
    // Predictor state. peer_ranks follows the block's table in the order
    // words are accepted; loaded_ranks follows it in the order words are
    // queued and only steers the choice of search ranks.
    // ------------------------------------------------------------------
    logic [RANKF_W-1:0]  peer_ranks   [GROUP_MAX_DEF];
    logic [RANKF_W-1:0]  loaded_ranks [GROUP_MAX_DEF];
    logic [GCOUNT_W-1:0] mdl_group = GCOUNT_W'(1);
    logic [OWN_W-1:0]    mdl_own   = '0;
    logic [RADIX_W-1:0]  mdl_radix = RADIX_W'(2);
    logic                mdl_mode  = MODE_KNOMIAL;

    in_word_t  cmd_words[$];         // words waiting to be offered
    out_word_t peer_answers_due[$];  // predicted lookup answers, oldest first

    int errors       = 0;
    int items_queued = 0;
    bit steady       = 1'b0;  // no idling on either side while set
    bit word_taken   = 1'b0;  // the word on in_word went in at the last rising edge
    bit hold_go      = 1'b0;
    bit drain_hold   = 1'b0;  // receiver refuses results while set

    // Walk the tree peers of own index in order; first rank match wins.
    function automatic out_word_t find_tree_peer(logic [RANKF_W-1:0] rank);
        out_word_t res;
        int gs;
        int radix;
        int offset;
        int rpow;
        int span;
        int lvl;
        int cand;
        res = '0;
        gs  = (mdl_group > GROUP_MAX_DEF) ? GROUP_MAX_DEF : int'(mdl_group);
        lvl = 0;
        offset = 1;
        if (mdl_mode == MODE_BINOMIAL)
        begin
            // partners own ^ 1, 2, 4 ...; those outside the group are skipped
            while (offset < gs)
            begin
                cand = int'(mdl_own) ^ offset;
                if (cand < gs && peer_ranks[cand] == rank)
                begin
                    res.found      = 1'b1;
                    res.peer_index = cand[EIDX_W-1:0];
                    res.level      = lvl[LVL_W-1:0];
                    return res;
                end
                offset = offset << 1;
                lvl++;
            end
        end
        else
        begin
            // radix 0 and 1 behave as 2
            radix = (mdl_radix < 2) ? 2 : int'(mdl_radix);
            rpow  = 1;
            while (offset < gs)
            begin
                span = radix * rpow;
                if (offset % span != 0)
                begin
                    // own - offset, wrapped by the group size
                    cand = (int'(mdl_own) >= offset) ? int'(mdl_own) - offset
                                                     : int'(mdl_own) + gs - offset;
                    if (cand < gs && peer_ranks[cand] == rank)
                    begin
                        res.found      = 1'b1;
                        res.peer_index = cand[EIDX_W-1:0];
                        res.level      = lvl[LVL_W-1:0];
                        return res;
                    end
                    offset += rpow;
                end
                else
                begin
                    // offset hit a multiple of radix^(level+1): next level up
                    rpow = span;
                    lvl++;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Acceptance is seen at the rising edge; the next word is
    // put up at the falling edge. A word that is up stays up until taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_taken = 1'b1;
            void'(cmd_words.pop_front());
            if (in_word.opcode == OP_WRITE)
                peer_ranks[in_word.entry_index] = in_word.entry_rank;
            else
                peer_answers_due.push_back(find_tree_peer(in_word.source_rank));
        end
    end

    always @(negedge clk)
    begin
        if (!in_valid || word_taken)
        begin
            if (cmd_words.size() != 0 && (steady || $urandom_range(99) >= 27))
            begin
                in_valid <= 1'b1;
                in_word  <= cmd_words[0];
            end
            else
                in_valid <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure, plus one long hold-off that lets
    // the block fill up and stall its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= !drain_hold && (steady || $urandom_range(99) >= 27);

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        drain_hold = 1'b1;
        repeat (500) @(posedge clk);
        drain_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (out_valid && out_ready)
        begin
            if (peer_answers_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: found %0b peer %0d level %0d",
                         $time, out_word.found, out_word.peer_index, out_word.level);
            end
            else
            begin
                want = peer_answers_due.pop_front();
                if (out_word.found !== want.found || out_word.peer_index !== want.peer_index
                    || out_word.level !== want.level)
                begin
                    errors++;
                    $display("%0t: mismatch: expected found %0b peer %0d level %0d, got found %0b peer %0d level %0d",
                             $time, want.found, want.peer_index, want.level,
                             out_word.found, out_word.peer_index, out_word.level);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Half the ranks come from a small pool so lookups meet duplicates.
    function automatic logic [RANKF_W-1:0] pick_rank();
        if ($urandom_range(1) == 0)
            return RANKF_W'($urandom_range(15));
        return RANKF_W'($urandom);
    endfunction

    // Fields a word does not use carry random junk.
    function automatic void push_write(int idx, logic [RANKF_W-1:0] rank);
        in_word_t w;
        w.opcode      = OP_WRITE;
        w.entry_index = EIDX_W'(idx);
        w.entry_rank  = rank;
        w.source_rank = RANKF_W'($urandom);
        cmd_words.push_back(w);
        loaded_ranks[idx] = rank;
        items_queued++;
    endfunction

    function automatic void push_lookup(logic [RANKF_W-1:0] rank);
        in_word_t w;
        w.opcode      = OP_LOOKUP;
        w.entry_index = EIDX_W'($urandom);
        w.entry_rank  = RANKF_W'($urandom);
        w.source_rank = rank;
        cmd_words.push_back(w);
        items_queued++;
    endfunction

    // Nothing queued, nothing offered, nothing owed; a trailing write may
    // still sit in the block's short queue, so give it time to reach the table.
    task automatic wait_drained();
        while (cmd_words.size() != 0 || in_valid || peer_answers_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_GROUP_COUNT: mdl_group = data;
            CFG_OWN_INDEX:   mdl_own   = data[OWN_W-1:0];
            CFG_TREE_RADIX:  mdl_radix = data;
            CFG_TREE_MODE:   mdl_mode  = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // New tree setup, only once the block has gone quiet.
    task automatic tree_setup(int gc, int own, int radix, int mode);
        wait_drained();
        write_reg(CFG_GROUP_COUNT, CFG_DAT_W'(gc));
        write_reg(CFG_OWN_INDEX,   CFG_DAT_W'(own));
        write_reg(CFG_TREE_RADIX,  CFG_DAT_W'(radix));
        write_reg(CFG_TREE_MODE,   CFG_DAT_W'(mode));
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;
        int gc;
        int eff;
        int own;
        int radix;
        int mode;
        int k;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset setup is a one-member group: no peers, nothing read
        push_lookup(16'h0000);

        // load every entry so no lookup can touch an unwritten one;
        // the rank extremes sit at the index extremes
        for (k = 0; k < GROUP_MAX_DEF; k++)
            push_write(k, (k == 0) ? 16'h0000 : (k == GROUP_MAX_DEF - 1) ? 16'hFFFF
                                                                         : pick_rank());

        // binomial over the full group: nearest partner, top level, max rank
        tree_setup(256, 0, 2, MODE_BINOMIAL);
        push_write(1, 16'hBEEF);
        push_lookup(16'hBEEF);
        push_lookup(loaded_ranks[128]);
        push_lookup(16'hFFFF);

        // k-nomial from the last member
        tree_setup(256, 255, 2, MODE_KNOMIAL);
        push_lookup(16'h0000);
        push_lookup(loaded_ranks[254]);

        // radix as large as the group: every peer on level 0
        tree_setup(256, 255, 256, MODE_KNOMIAL);
        push_lookup(loaded_ranks[0]);

        // empty group in both modes
        tree_setup(0, 0, 2, MODE_KNOMIAL);
        push_lookup(loaded_ranks[0]);
        tree_setup(0, 0, 2, MODE_BINOMIAL);
        push_lookup(loaded_ranks[1]);

        // oversized group clipped to the table, radix 0 taken as 2
        tree_setup(511, 7, 0, MODE_KNOMIAL);
        push_lookup(loaded_ranks[200]);
        push_lookup(16'hFFFF);

        // radix 1 taken as 2 is harmless in binomial mode; oversized group
        tree_setup(300, 100, 1, MODE_BINOMIAL);
        push_lookup(loaded_ranks[100 ^ 64]);

        // own index outside the group: partners beyond it are skipped
        tree_setup(100, 200, 3, MODE_BINOMIAL);
        push_lookup(loaded_ranks[201]);
        tree_setup(100, 200, 3, MODE_KNOMIAL);
        push_lookup(loaded_ranks[150]);

        // two members, maximum radix
        tree_setup(2, 1, 511, MODE_KNOMIAL);
        push_lookup(loaded_ranks[0]);

        // Random phases: mostly small groups to keep walks short, some full
        // ones, a few empty or oversized; radix and own index stray past
        // their ranges now and then.
        phase = 0;
        while (items_queued < 1900)
        begin
            phase++;
            k = $urandom_range(99);
            if (k < 70)
                gc = $urandom_range(1, 40);
            else if (k < 88)
                gc = $urandom_range(41, 256);
            else if (k < 94)
                gc = $urandom_range(257, 511);
            else
                gc = 0;
            eff = (gc == 0) ? 1 : (gc > GROUP_MAX_DEF) ? GROUP_MAX_DEF : gc;
            own = ($urandom_range(99) < 80) ? $urandom_range(0, eff - 1) : $urandom_range(0, 511);
            k = $urandom_range(99);
            if (k < 75)
                radix = $urandom_range(2, 8);
            else if (k < 85)
                radix = $urandom_range(0, 1);
            else
                radix = $urandom_range(9, 511);
            mode = $urandom_range(0, 1);
            if ($urandom_range(3) == 0)
                mode |= $urandom_range(1, 255) << 1;  // junk above the mode bit
            tree_setup(gc, own, radix, mode);

            // every phase starts idle, so the sender has paused for all answers;
            // phase 2 also starves the output, phase 3 runs flat out
            steady = (phase == 3);
            if (phase == 2)
                hold_go = 1'b1;

            n = $urandom_range(40, 80);
            repeat (n)
            begin
                if ($urandom_range(99) < 30)
                    push_write($urandom_range(0, GROUP_MAX_DEF - 1), pick_rank());
                else if ($urandom_range(99) < 80)
                    push_lookup(loaded_ranks[$urandom_range(0, eff - 1)]);
                else
                    push_lookup(RANKF_W'($urandom));
            end
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0 && peer_answers_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #40000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
